>>> rtl/iae_pkg.sv
// Shared types and constants for the add/subtract expression evaluator.
// Used by the front end, the op queue, the back end, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package iae_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int PAREN_DEPTH = 16;

   // Nesting level counts 0..PAREN_DEPTH; stack index addresses 0..PAREN_DEPTH-1.
   localparam int LVL_W = $clog2(PAREN_DEPTH + 1);
   localparam int IDX_W = (PAREN_DEPTH > 1) ? $clog2(PAREN_DEPTH) : 1;

   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNMATCHED = 2'd1;
   localparam logic [1:0] ST_DEEP      = 2'd2;
   localparam logic [1:0] ST_CHAR      = 2'd3;

   typedef enum logic [2:0] {
      OP_DIGIT,
      OP_PLUS,
      OP_MINUS,
      OP_OPEN,
      OP_CLOSE,
      OP_NOP,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [1:0]                    status;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
      logic       last;
   } q_entry_type;

endpackage

>>> rtl/iae_front.sv
// Front end: decodes each incoming character beat into a queue op.
// Depends on iae_pkg. Feeds iae_queue.
`timescale 1ns / 1ps

module iae_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  iae_pkg::req_type     req_data,
   input  logic                 q_full,
   output logic                 q_push,
   output iae_pkg::q_entry_type q_wr_entry
);
   import iae_pkg::*;

   op_type op;

   always_comb begin
      unique case (req_data.character) inside
         [CH_ZERO:CH_NINE]: op = OP_DIGIT;
         CH_PLUS:           op = OP_PLUS;
         CH_MINUS:          op = OP_MINUS;
         CH_OPEN:           op = OP_OPEN;
         CH_CLOSE:          op = OP_CLOSE;
         CH_SPACE:          op = OP_NOP;
         default:           op = OP_BAD;
      endcase
   end

   assign req_ready = !q_full;

   // Spaces carry no work; only a space that ends the expression goes through.
   assign q_push = req_valid && !q_full && (req_data.last || (op != OP_NOP));

   assign q_wr_entry.op    = op;
   assign q_wr_entry.digit = req_data.character[3:0];
   assign q_wr_entry.last  = req_data.last;

endmodule

>>> rtl/iae_queue.sv
// Short op queue between the front end and the back end.
// Depends on iae_pkg for the entry type and depth.
`timescale 1ns / 1ps

module iae_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  iae_pkg::q_entry_type wr_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 rd_valid,
   output iae_pkg::q_entry_type rd_entry
);
   import iae_pkg::*;

   q_entry_type            mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff;
   logic [QPTR_W-1:0]      wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff;
   logic [QPTR_W-1:0]      rd_ptr_in;
   logic [QCNT_W-1:0]      count_ff;
   logic [QCNT_W-1:0]      count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == QCNT_W'(Q_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && rd_valid;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

>>> rtl/iae_back.sv
// Back end: executes one queued op per cycle when one is queued (a last op also waits
// for a free result slot) against the running total, the signed current term and the
// parenthesis stack, then finishes and holds the result. Depends on iae_pkg.
`timescale 1ns / 1ps

module iae_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  iae_pkg::q_entry_type q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output iae_pkg::rsp_type     rsp_data
);
   import iae_pkg::*;

   // The current number is kept with its sign already applied, so a term
   // closes with a single add.
   logic [VALUE_WIDTH-1:0] total_ff, total_in;
   logic [VALUE_WIDTH-1:0] term_ff, term_in;
   logic                   sign_ff, sign_in;
   logic [LVL_W-1:0]       level_ff, level_in;
   logic [1:0]             err_ff, err_in;

   logic [VALUE_WIDTH-1:0] stk_total_ff [PAREN_DEPTH];
   logic                   stk_sign_ff  [PAREN_DEPTH];

   logic                   pend_valid_ff, pend_valid_in;
   logic [VALUE_WIDTH-1:0] pend_total_ff, pend_term_ff;
   logic [1:0]             pend_status_ff, pend_status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff;

   logic                   pend_move;
   logic                   pend_free;
   logic                   exec;
   logic                   finish;
   logic                   push_en;
   logic [IDX_W-1:0]       push_idx;
   logic [IDX_W-1:0]       pop_idx;
   logic [VALUE_WIDTH-1:0] t_close;
   logic [VALUE_WIDTH-1:0] term_x10;
   logic [VALUE_WIDTH-1:0] digit_ext;
   logic [VALUE_WIDTH-1:0] pend_sum;

   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pend_free = !pend_valid_ff || pend_move;
   assign exec      = q_valid && (!q_entry.last || pend_free);
   assign finish    = exec && q_entry.last;
   assign q_pop     = exec;

   assign push_idx  = level_ff[IDX_W-1:0];
   assign pop_idx   = IDX_W'(level_ff - 1'b1);
   assign t_close   = total_ff + term_ff;
   assign term_x10  = (term_ff << 3) + (term_ff << 1);
   assign digit_ext = VALUE_WIDTH'(q_entry.digit);

   always_comb begin
      total_in = total_ff;
      term_in  = term_ff;
      sign_in  = sign_ff;
      level_in = level_ff;
      err_in   = err_ff;
      push_en  = 1'b0;

      unique case (q_entry.op) inside
         OP_DIGIT: begin
            term_in = sign_ff ? (term_x10 - digit_ext) : (term_x10 + digit_ext);
         end
         OP_PLUS, OP_MINUS: begin
            total_in = t_close;
            term_in  = '0;
            sign_in  = (q_entry.op == OP_MINUS);
         end
         OP_OPEN: begin
            if (level_ff == LVL_W'(PAREN_DEPTH)) begin
               if (err_ff == ST_OK) err_in = ST_DEEP;
            end else begin
               push_en  = 1'b1;
               level_in = LVL_W'(level_ff + 1'b1);
               total_in = '0;
               term_in  = '0;
               sign_in  = 1'b0;
            end
         end
         OP_CLOSE: begin
            if (level_ff == '0) begin
               if (err_ff == ST_OK) err_in = ST_UNMATCHED;
            end else begin
               level_in = LVL_W'(level_ff - 1'b1);
               total_in = stk_sign_ff[pop_idx] ? (stk_total_ff[pop_idx] - t_close)
                                               : (stk_total_ff[pop_idx] + t_close);
               term_in  = '0;
               sign_in  = 1'b0;
            end
         end
         OP_BAD: begin
            if (err_ff == ST_OK) err_in = ST_CHAR;
         end
         default: begin
         end
      endcase

      if (err_in != ST_OK) begin
         pend_status_in = err_in;
      end else if (level_in != '0) begin
         pend_status_in = ST_UNMATCHED;
      end else begin
         pend_status_in = ST_OK;
      end
   end

   assign pend_valid_in = finish ? 1'b1 : (pend_move ? 1'b0 : pend_valid_ff);
   assign rsp_valid_in  = pend_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign pend_sum      = pend_total_ff + pend_term_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff      <= '0;
         term_ff       <= '0;
         sign_ff       <= 1'b0;
         level_ff      <= '0;
         err_ff        <= ST_OK;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (finish) begin
            // The expression is done: start the next one from a clean state.
            total_ff <= '0;
            term_ff  <= '0;
            sign_ff  <= 1'b0;
            level_ff <= '0;
            err_ff   <= ST_OK;
         end else if (exec) begin
            total_ff <= total_in;
            term_ff  <= term_in;
            sign_ff  <= sign_in;
            level_ff <= level_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec && push_en) begin
         stk_total_ff[push_idx] <= total_ff;
         stk_sign_ff[push_idx]  <= sign_ff;
      end
      if (finish) begin
         pend_total_ff  <= total_in;
         pend_term_ff   <= term_in;
         pend_status_ff <= pend_status_in;
      end
      if (pend_move) begin
         rsp_data_ff.status <= pend_status_ff;
         rsp_data_ff.value  <= (pend_status_ff == ST_OK) ? $signed(pend_sum) : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/infix_add_sub_expression_evaluator_top.sv
// Add/subtract expression evaluator with parentheses, one character per beat.
// Throughput: one character per cycle unless a pending result stalls, set by the back
// end's single close-term adder path; a closing ')' folds the sub-total in that same cycle.
// The last beat goes through the op queue, the pending stage and the result register.
// Reset (synchronous, active high) empties the queue and the result stages and
// clears the total, term, sign, nesting level and status; no clearing pass.
`timescale 1ns / 1ps

module infix_add_sub_expression_evaluator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iae_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output iae_pkg::rsp_type rsp_data
);
   import iae_pkg::*;

   logic        q_full;
   logic        q_push;
   logic        q_pop;
   logic        q_valid;
   q_entry_type q_wr_entry;
   q_entry_type q_rd_entry;

   iae_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wr_entry (q_wr_entry)
   );

   iae_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_entry (q_rd_entry)
   );

   iae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_rd_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/iae_checker.sv
// Port-level checks for the expression evaluator, bound to the top level.
// Depends on iae_pkg and the top level's port list.
`timescale 1ns / 1ps

module iae_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input iae_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input iae_pkg::rsp_type rsp_data
);
   import iae_pkg::*;

   // Expressions whose last beat went in and whose result has not been taken.
   logic [3:0] open_ff, open_in;
   logic       last_in;
   logic       rsp_done;

   assign last_in  = req_valid && req_ready && req_data.last;
   assign rsp_done = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (last_in && !rsp_done) begin
         open_in = open_ff + 4'd1;
      end else if (rsp_done && !last_in) begin
         open_in = open_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed or dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OK) |-> (rsp_data.value == '0))
      else $error("error result carries a nonzero value");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (open_ff != 4'd0))
      else $error("result beat without a matching last character");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 4'd6)
      else $error("more expressions in flight than the pipeline can hold");

endmodule

bind infix_add_sub_expression_evaluator_top iae_checker u_iae_checker (.*);
